/* sv/intdet_pkg.sv */
// intdet_pkg: shared constants for the integer determinant block
// field widths, configuration defaults and parameter defaults
// no dependencies; imported by the top level and its checker
package intdet_pkg;

    // default matrix size limit and arithmetic word width
    localparam int MAX_DIM_DEF   = 12;
    localparam int WORD_BITS_DEF = 32;

    // fixed widths of the stream fields and the configuration register
    localparam int ENTRY_W = 32;
    localparam int DET_W   = 32;
    localparam int DIM_W   = 4;

    // dimension after reset
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

endpackage

/* sv/integer_determinant.sv */
// Integer matrix determinant by cofactor expansion over column subsets.
// Usage:
//   cfg_wr_en / cfg_wr_data set the dimension n (0 reads as 1, values above
//   MAX_DIM saturate); a write also drops any partly loaded matrix.
//   s_tdata carries one signed matrix entry per transaction, row-major.
//   After the n*n-th entry the block computes and presents one transaction
//   on m_tdata: the determinant modulo 2^WORD_BITS, zero-extended or
//   truncated to 32 bits.
// Operation:
//   loading accepts one entry per cycle. The expansion then walks every
//   non-empty column subset S in increasing order; for each it issues one
//   multiply-accumulate per set column through a three-stage
//   read/multiply/accumulate pipeline, then waits until the minor of S is
//   written back to the minor table, which the next subset may read.
// Reset clears the counters and the output valid; both memories start
// undefined, and every entry that the expansion uses is written before use.
// A stalled receiver leaves the result in the output register; the next
// matrix is loaded meanwhile and its result waits until that register frees.
module integer_determinant #(
    parameter int MAX_DIM   = intdet_pkg::MAX_DIM_DEF,
    parameter int WORD_BITS = intdet_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // dimension register write
    input  logic                             cfg_wr_en,
    input  logic [intdet_pkg::DIM_W-1:0]     cfg_wr_data,
    // entry stream; tdata: entry[31:0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [intdet_pkg::ENTRY_W-1:0]   s_tdata,
    // result stream; tdata: determinant[31:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [intdet_pkg::DET_W-1:0]     m_tdata
);
    import intdet_pkg::*;

    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int NW        = $clog2(MAX_DIM + 1);
    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
    localparam int MADDR_W   = $clog2(MAT_DEPTH);
    localparam int TAB_DEPTH = 1 << MAX_DIM;
    localparam int HI_W      = (WORD_BITS + 1) / 2;
    localparam int LO_W      = WORD_BITS - HI_W;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // control carried along the multiply-accumulate pipeline
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic               first;
        logic               last;
        logic               fin;
        logic [MAX_DIM-1:0] sub;
    } mac_ctl_t;

    function automatic logic [NW-1:0] popcnt(input logic [MAX_DIM-1:0] v);
        logic [NW-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            cnt = cnt + NW'(v[i]);
        end
        return cnt;
    endfunction

    function automatic logic [CNT_W-1:0] lowest(input logic [MAX_DIM-1:0] v);
        logic [CNT_W-1:0] idx;
        idx = '0;
        for (int i = MAX_DIM - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = CNT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [MADDR_W-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                                    input logic [CNT_W-1:0] c);
        return MADDR_W'(r * MAX_DIM) + MADDR_W'(c);
    endfunction

    logic [DIM_W-1:0]     dim_reg;
    logic [1:0]           state_reg;
    logic [CNT_W-1:0]     row_reg;
    logic [CNT_W-1:0]     col_reg;
    logic [MAX_DIM-1:0]   subset_reg;
    logic [MAX_DIM-1:0]   remain_reg;
    logic                 pos_reg;
    logic [1:0]           wait_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] det_reg;
    logic                 m_tvalid_reg;
    logic [DET_W-1:0]     m_tdata_reg;

    logic [WORD_BITS-1:0] mat_mem [MAT_DEPTH];
    logic [WORD_BITS-1:0] tab_mem [TAB_DEPTH];
    logic [WORD_BITS-1:0] mat_rd_reg;
    logic [WORD_BITS-1:0] tab_rd_reg;

    // effective dimension and derived limits
    logic [NW-1:0]      dim_eff;
    logic [CNT_W-1:0]   idx_last;
    logic [MAX_DIM-1:0] full_mask;

    always_comb begin
        if (dim_reg == '0) begin
            dim_eff = NW'(1);
        end else if (int'(dim_reg) > MAX_DIM) begin
            dim_eff = NW'(MAX_DIM);
        end else begin
            dim_eff = NW'(dim_reg);
        end
    end

    assign idx_last  = CNT_W'(dim_eff - NW'(1));
    assign full_mask = ~({MAX_DIM{1'b1}} << dim_eff);

    // load side
    logic                     s_accept;
    logic                     load_last;
    logic signed [ENTRY_W-1:0] entry_s;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign load_last = (row_reg == idx_last) && (col_reg == idx_last);
    assign entry_s   = s_tdata;

    // issue of one product per cycle while no write-back wait is pending: lowest column still pending in the subset
    logic               issue;
    logic [CNT_W-1:0]   col_pick;
    logic [MAX_DIM-1:0] col_bit;
    logic [MAX_DIM-1:0] remain_left;
    logic [CNT_W-1:0]   subset_row;
    logic [MADDR_W-1:0] mat_raddr;
    logic [MAX_DIM-1:0] tab_raddr;

    assign issue       = (state_reg == ST_CALC) && (wait_reg == 2'd0);
    assign col_pick    = lowest(remain_reg);
    assign col_bit     = MAX_DIM'(1) << col_pick;
    assign remain_left = remain_reg & ~col_bit;
    assign subset_row  = CNT_W'(dim_eff - popcnt(subset_reg));
    assign mat_raddr   = mat_addr(subset_row, col_pick);
    assign tab_raddr   = subset_reg & ~col_bit;

    // pipeline stage registers
    mac_ctl_t             ctl1_reg;
    mac_ctl_t             ctl2_reg;
    logic                 zero1_reg;
    logic [WORD_BITS-1:0] plo_reg;
    logic [LO_W-1:0]      cr1_reg;
    logic [LO_W-1:0]      cr2_reg;

    // matrix store: written while loading, read during the expansion
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mat_mem[mat_addr(row_reg, col_reg)] <= WORD_BITS'(entry_s);
        end
        mat_rd_reg <= mat_mem[mat_raddr];
    end

    // multiply stage: product split into three half-width partial products
    logic [WORD_BITS-1:0]   op_a;
    logic [WORD_BITS-1:0]   op_b;
    logic [2*HI_W-1:0]      p_lo;
    logic [HI_W+LO_W-1:0]   p_c1;
    logic [HI_W+LO_W-1:0]   p_c2;

    // the empty minor is one and is never stored
    assign op_a = mat_rd_reg;
    assign op_b = zero1_reg ? WORD_BITS'(1) : tab_rd_reg;
    assign p_lo = op_a[HI_W-1:0] * op_b[HI_W-1:0];
    assign p_c1 = op_a[HI_W-1:0] * op_b[WORD_BITS-1:HI_W];
    assign p_c2 = op_a[WORD_BITS-1:HI_W] * op_b[HI_W-1:0];

    always_ff @(posedge aclk) begin
        plo_reg <= p_lo[WORD_BITS-1:0];
        cr1_reg <= p_c1[LO_W-1:0];
        cr2_reg <= p_c2[LO_W-1:0];
    end

    // accumulate stage with alternating signs
    logic [WORD_BITS-1:0] term;
    logic [WORD_BITS-1:0] acc_base;
    logic [WORD_BITS-1:0] acc_next;

    assign term     = plo_reg + {cr1_reg + cr2_reg, {HI_W{1'b0}}};
    assign acc_base = ctl2_reg.first ? '0 : acc_reg;
    assign acc_next = ctl2_reg.neg ? acc_base - term : acc_base + term;

    // minor table: read at issue, written when a subset's last term lands
    always_ff @(posedge aclk) begin
        if (ctl2_reg.valid && ctl2_reg.last) begin
            tab_mem[ctl2_reg.sub] <= acc_next;
        end
        tab_rd_reg <= tab_mem[tab_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (ctl2_reg.valid && ctl2_reg.fin) begin
            det_reg <= acc_next;
        end
        zero1_reg <= (tab_raddr == '0);
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg.valid <= issue;
            ctl1_reg.neg   <= pos_reg;
            ctl1_reg.first <= !pos_reg && (remain_reg == subset_reg);
            ctl1_reg.last  <= (remain_left == '0);
            ctl1_reg.fin   <= (remain_left == '0) && (subset_reg == full_mask);
            ctl1_reg.sub   <= subset_reg;
            ctl2_reg       <= ctl1_reg;
        end
    end

    // sequencer: loading, subset walk, result hand-off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg      <= DIM_RESET;
            state_reg    <= ST_LOAD;
            row_reg      <= '0;
            col_reg      <= '0;
            subset_reg   <= '0;
            remain_reg   <= '0;
            pos_reg      <= 1'b0;
            wait_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output register: filled by a finished result, emptied once taken
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (cfg_wr_en) begin
                        dim_reg <= cfg_wr_data;
                        row_reg <= '0;
                        col_reg <= '0;
                    end else if (s_accept) begin
                        if (load_last) begin
                            row_reg    <= '0;
                            col_reg    <= '0;
                            subset_reg <= MAX_DIM'(1);
                            remain_reg <= MAX_DIM'(1);
                            pos_reg    <= 1'b0;
                            wait_reg   <= 2'd0;
                            state_reg  <= ST_CALC;
                        end else if (col_reg == idx_last) begin
                            col_reg <= '0;
                            row_reg <= row_reg + CNT_W'(1);
                        end else begin
                            col_reg <= col_reg + CNT_W'(1);
                        end
                    end
                end
                ST_CALC: begin
                    if (wait_reg != 2'd0) begin
                        wait_reg <= wait_reg - 2'd1;
                        if (wait_reg == 2'd1) begin
                            if (subset_reg == full_mask) begin
                                state_reg <= ST_DONE;
                            end else begin
                                subset_reg <= subset_reg + MAX_DIM'(1);
                                remain_reg <= subset_reg + MAX_DIM'(1);
                                pos_reg    <= 1'b0;
                            end
                        end
                    end else begin
                        remain_reg <= remain_left;
                        pos_reg    <= !pos_reg;
                        if (remain_left == '0) begin
                            wait_reg <= 2'd2;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= DET_W'(det_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/intdet_checker.sv */
// intdet_checker: port-level assertions for the integer determinant block
// uses intdet_pkg for field widths; bound to integer_determinant below
// sees only the top-level ports
module intdet_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [intdet_pkg::DET_W-1:0]   m_tdata
);
    import intdet_pkg::*;

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an entry transaction never produces a result in the very next cycle
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after an entry");

    // a new result is only handed over while input is held off
    a_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result handed over while loading");

endmodule

bind integer_determinant intdet_checker u_intdet_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
